[src/mf2_pkg.sv]
`default_nettype none

package mf2_pkg;

    // Pixel and register geometry
    localparam int PIX_W  = 8;
    localparam int CFG_W  = 12;
    localparam int CFG_IW = 1;
    localparam int DIM_W  = 13;

    localparam logic [CFG_W-1:0] WIDTH_RESET  = 12'd640;
    localparam logic [CFG_W-1:0] HEIGHT_RESET = 12'd480;

    // Register indexes
    localparam logic [CFG_IW-1:0] REG_WIDTH  = 1'b0;
    localparam logic [CFG_IW-1:0] REG_HEIGHT = 1'b1;

    // Input commands
    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_DRAIN = 1'b1;

    typedef logic [PIX_W-1:0] t_pix;

    typedef struct packed {
        logic command;
        t_pix pixel_in;
    } t_in;

    typedef struct packed {
        t_pix pixel_out;
        logic frame_last;
    } t_out;

    // Result bookkeeping that rides along the median cells
    typedef struct packed {
        logic valid;
        logic is_median;
        logic frame_last;
        t_pix border;
    } t_meta;

endpackage

`default_nettype wire

[src/median_filter_2d.sv]
// median_filter_2d: streaming 2-D median filter for 8-bit grayscale frames.
// Input channel (i_in_valid / o_in_ready / i_in_data) takes one item per
// cycle: a pixel in raster order, or a drain command that flushes one held
// pixel after the frame's last input pixel. Output channel (o_out_valid /
// i_out_ready / o_out_data) gives filtered pixels in raster order; frame_last
// marks the final pixel of a frame. Border pixels are copied unchanged.
// Throughput: one item per cycle while o_in_ready is high. Each item passes
// through a line store read, the window registers and one median cell per
// pixel bit; in the image a result trails the input by WINDOW/2 rows plus
// WINDOW/2 pixels. The cfg port (i_cfg_we, i_cfg_index, i_cfg_data) sets
// width and height; a write restarts the frame. A write must be made only
// while the block is idle; the block does not enforce this. Reset restores
// 640x480 and restarts the frame; no clearing pass is run. When the
// receiver stalls, an output register and a skid register hold results;
// the block keeps taking items until the skid register fills.

`default_nettype none

module median_filter_2d
    import mf2_pkg::*;
#(
    parameter int WINDOW     = 7,
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 2048
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_in_valid,
    output logic              o_in_ready,
    input  t_in               i_in_data,
    output logic              o_out_valid,
    input  wire               i_out_ready,
    output t_out              o_out_data,
    input  wire               i_cfg_we,
    input  wire  [CFG_IW-1:0] i_cfg_index,
    input  wire  [CFG_W-1:0]  i_cfg_data
);

    localparam int HALF   = WINDOW / 2;
    localparam int SPAN   = 2 * HALF + 1;
    localparam int SLOTS  = SPAN - 1;
    localparam int N      = WINDOW * WINDOW;
    localparam int MED    = N / 2;
    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int ROW_W  = $clog2(MAX_HEIGHT + 1);
    localparam int SLOT_W = $clog2(SLOTS);
    localparam int FILL_W = $clog2(HALF * MAX_WIDTH + HALF + 1);
    localparam int CNT_W  = $clog2(N + 1);

    typedef struct packed {
        logic              shift;
        logic              result;
        logic              is_median;
        logic              frame_last;
        logic [SLOT_W-1:0] in_slot;
        logic [SLOT_W-1:0] out_slot;
        t_pix              pix;
    } t_s1;

    // Configuration and frame position
    logic [CFG_W-1:0]  r_width;
    logic [CFG_W-1:0]  r_height;
    logic [COL_W-1:0]  r_in_col;
    logic [ROW_W-1:0]  r_in_row;
    logic [SLOT_W-1:0] r_in_slot;
    logic [COL_W-1:0]  r_out_col;
    logic [ROW_W-1:0]  r_out_row;
    logic [SLOT_W-1:0] r_out_slot;
    logic [FILL_W-1:0] r_fill;

    logic              w_en;
    logic              acc;
    logic              is_drain;
    logic [DIM_W-1:0]  w_eff;
    logic [DIM_W-1:0]  h_eff;
    logic [FILL_W-1:0] lag;
    logic              restart;
    logic [COL_W-1:0]  c_in_col;
    logic [ROW_W-1:0]  c_in_row;
    logic [SLOT_W-1:0] c_in_slot;
    logic [COL_W-1:0]  c_out_col;
    logic [ROW_W-1:0]  c_out_row;
    logic [SLOT_W-1:0] c_out_slot;
    logic [FILL_W-1:0] c_fill;
    logic [COL_W-1:0]  s_out_col;
    logic [ROW_W-1:0]  s_out_row;
    logic [SLOT_W-1:0] s_out_slot;
    logic              issue;
    logic              interior;
    logic              last_px;
    logic [COL_W-1:0]  n_out_col;
    logic [ROW_W-1:0]  n_out_row;
    logic [SLOT_W-1:0] n_out_slot;
    logic [COL_W-1:0]  n_in_col;
    logic [ROW_W-1:0]  n_in_row;
    logic [SLOT_W-1:0] n_in_slot;
    logic [FILL_W-1:0] n_fill;

    t_pix  rd_a [SLOTS];
    t_pix  rd_b [SLOTS];
    t_pix  col  [SPAN];
    t_s1   r_s1;
    t_meta r_s2;
    t_pix  r_win [SPAN][SPAN];

    // Median cell chain
    logic [N-1:0][PIX_W-1:0] ch_vals  [PIX_W+1];
    logic [N-1:0]            ch_alive [PIX_W+1];
    logic [CNT_W-1:0]        ch_rank  [PIX_W+1];
    t_pix                    ch_bits  [PIX_W+1];
    t_meta                   ch_meta  [PIX_W+1];

    // Output register and skid register
    logic r_ov;
    t_out r_od;
    logic r_sv;
    t_out r_sd;
    t_out p_data;
    logic p_valid;

    assign w_en       = !r_sv;
    assign o_in_ready = w_en;
    assign acc        = i_in_valid && w_en;
    assign is_drain   = (i_in_data.command == CMD_DRAIN);

    // Work out the position and kind of the item at the input
    always_comb begin
        if (r_width == '0) begin
            w_eff = DIM_W'(1);
        end else if (DIM_W'(r_width) > DIM_W'(MAX_WIDTH)) begin
            w_eff = DIM_W'(MAX_WIDTH);
        end else begin
            w_eff = DIM_W'(r_width);
        end
        if (r_height == '0) begin
            h_eff = DIM_W'(1);
        end else if (DIM_W'(r_height) > DIM_W'(MAX_HEIGHT)) begin
            h_eff = DIM_W'(MAX_HEIGHT);
        end else begin
            h_eff = DIM_W'(r_height);
        end
        lag = FILL_W'(w_eff) * FILL_W'(HALF) + FILL_W'(HALF);

        restart = (DIM_W'(r_in_row) >= h_eff) || (DIM_W'(r_in_col) >= w_eff);
        c_in_col   = restart ? '0 : r_in_col;
        c_in_row   = restart ? '0 : r_in_row;
        c_in_slot  = restart ? '0 : r_in_slot;
        c_out_col  = restart ? '0 : r_out_col;
        c_out_row  = restart ? '0 : r_out_row;
        c_out_slot = restart ? '0 : r_out_slot;
        c_fill     = restart ? '0 : r_fill;

        if (is_drain) begin
            s_out_col  = r_out_col;
            s_out_row  = r_out_row;
            s_out_slot = r_out_slot;
            issue      = (DIM_W'(r_in_row) >= h_eff) && (DIM_W'(r_out_row) < h_eff);
        end else begin
            s_out_col  = c_out_col;
            s_out_row  = c_out_row;
            s_out_slot = c_out_slot;
            issue      = (c_fill >= lag) && (DIM_W'(c_out_row) < h_eff);
        end

        interior = !is_drain
                && (DIM_W'(s_out_col) >= DIM_W'(HALF))
                && (DIM_W'(s_out_col) + DIM_W'(HALF) < w_eff)
                && (DIM_W'(s_out_row) >= DIM_W'(HALF))
                && (DIM_W'(s_out_row) + DIM_W'(HALF) < h_eff);
        last_px  = (DIM_W'(s_out_row) == h_eff - DIM_W'(1))
                && (DIM_W'(s_out_col) == w_eff - DIM_W'(1));

        // Advance the output position
        if (DIM_W'(s_out_col) + DIM_W'(1) >= w_eff) begin
            n_out_col  = '0;
            n_out_row  = s_out_row + ROW_W'(1);
            n_out_slot = (s_out_slot == SLOT_W'(SLOTS - 1)) ? '0 : s_out_slot + SLOT_W'(1);
        end else begin
            n_out_col  = s_out_col + COL_W'(1);
            n_out_row  = s_out_row;
            n_out_slot = s_out_slot;
        end

        // Advance the input position
        if (DIM_W'(c_in_col) + DIM_W'(1) >= w_eff) begin
            n_in_col  = '0;
            n_in_row  = c_in_row + ROW_W'(1);
            n_in_slot = (c_in_slot == SLOT_W'(SLOTS - 1)) ? '0 : c_in_slot + SLOT_W'(1);
        end else begin
            n_in_col  = c_in_col + COL_W'(1);
            n_in_row  = c_in_row;
            n_in_slot = c_in_slot;
        end
        n_fill = (c_fill < lag) ? c_fill + FILL_W'(1) : c_fill;
    end

    // Hold configuration and frame counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width    <= WIDTH_RESET;
            r_height   <= HEIGHT_RESET;
            r_in_col   <= '0;
            r_in_row   <= '0;
            r_in_slot  <= '0;
            r_out_col  <= '0;
            r_out_row  <= '0;
            r_out_slot <= '0;
            r_fill     <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_WIDTH:  r_width  <= i_cfg_data;
                REG_HEIGHT: r_height <= i_cfg_data;
                default:    r_width  <= r_width;
            endcase
            r_in_col   <= '0;
            r_in_row   <= '0;
            r_in_slot  <= '0;
            r_out_col  <= '0;
            r_out_row  <= '0;
            r_out_slot <= '0;
            r_fill     <= '0;
        end else if (acc) begin
            if (is_drain) begin
                if (issue) begin
                    r_out_col  <= n_out_col;
                    r_out_row  <= n_out_row;
                    r_out_slot <= n_out_slot;
                end
            end else begin
                r_in_col  <= n_in_col;
                r_in_row  <= n_in_row;
                r_in_slot <= n_in_slot;
                r_fill    <= n_fill;
                if (issue) begin
                    r_out_col  <= n_out_col;
                    r_out_row  <= n_out_row;
                    r_out_slot <= n_out_slot;
                end else begin
                    r_out_col  <= c_out_col;
                    r_out_row  <= c_out_row;
                    r_out_slot <= c_out_slot;
                end
            end
        end
    end

    // Line store: one bank per held row
    for (genvar g = 0; g < SLOTS; g++) begin : g_bank
        mf2_line_bank #(
            .DEPTH (MAX_WIDTH)
        ) u_bank (
            .i_clk     (i_clk),
            .i_en      (w_en),
            .i_we      (acc && !is_drain && (c_in_slot == SLOT_W'(g))),
            .i_waddr   (c_in_col),
            .i_wdata   (i_in_data.pixel_in),
            .i_raddr_a (c_in_col),
            .i_raddr_b (s_out_col),
            .o_rdata_a (rd_a[g]),
            .o_rdata_b (rd_b[g])
        );
    end

    // Register the item's bookkeeping beside the line store read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1.shift  <= 1'b0;
            r_s1.result <= 1'b0;
        end else if (w_en) begin
            r_s1.shift      <= acc && !is_drain;
            r_s1.result     <= acc && issue;
            r_s1.is_median  <= interior;
            r_s1.frame_last <= last_px;
            r_s1.in_slot    <= c_in_slot;
            r_s1.out_slot   <= s_out_slot;
            r_s1.pix        <= i_in_data.pixel_in;
        end
    end

    // Rotate bank outputs into row order, oldest row first
    always_comb begin
        logic [SLOT_W:0] s;
        for (int k = 0; k < SLOTS; k++) begin
            s = (SLOT_W+1)'(r_s1.in_slot) + (SLOT_W+1)'(k);
            if (s >= (SLOT_W+1)'(SLOTS)) begin
                s = s - (SLOT_W+1)'(SLOTS);
            end
            col[k] = rd_a[s[SLOT_W-1:0]];
        end
        col[SLOTS] = r_s1.pix;
    end

    // Shift the new column into the window
    always_ff @(posedge i_clk) begin
        if (w_en && r_s1.shift) begin
            for (int k = 0; k < SPAN; k++) begin
                for (int i = 0; i < SPAN - 1; i++) begin
                    r_win[k][i] <= r_win[k][i+1];
                end
                r_win[k][SPAN-1] <= col[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2.valid <= 1'b0;
        end else if (w_en) begin
            r_s2.valid      <= r_s1.result;
            r_s2.is_median  <= r_s1.is_median;
            r_s2.frame_last <= r_s1.frame_last;
            r_s2.border     <= rd_b[r_s1.out_slot];
        end
    end

    // Feed the window into the first cell
    always_comb begin
        for (int i = 0; i < WINDOW; i++) begin
            for (int j = 0; j < WINDOW; j++) begin
                ch_vals[0][i*WINDOW+j] = r_win[i][j];
            end
        end
        ch_alive[0] = '1;
        ch_rank[0]  = CNT_W'(MED);
        ch_bits[0]  = '0;
        ch_meta[0]  = r_s2;
    end

    for (genvar b = 0; b < PIX_W; b++) begin : g_cell
        mf2_bit_cell #(
            .N   (N),
            .BIT (PIX_W - 1 - b)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_vals  (ch_vals[b]),
            .i_alive (ch_alive[b]),
            .i_rank  (ch_rank[b]),
            .i_bits  (ch_bits[b]),
            .i_meta  (ch_meta[b]),
            .o_vals  (ch_vals[b+1]),
            .o_alive (ch_alive[b+1]),
            .o_rank  (ch_rank[b+1]),
            .o_bits  (ch_bits[b+1]),
            .o_meta  (ch_meta[b+1])
        );
    end

    // Pick the median or the copied border pixel
    always_comb begin
        p_valid           = ch_meta[PIX_W].valid;
        p_data.pixel_out  = ch_meta[PIX_W].is_median ? ch_bits[PIX_W] : ch_meta[PIX_W].border;
        p_data.frame_last = ch_meta[PIX_W].frame_last;
    end

    // Hold results in the output and skid registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            r_sv <= 1'b0;
        end else if (!r_ov || i_out_ready) begin
            if (r_sv) begin
                r_ov <= 1'b1;
                r_od <= r_sd;
                r_sv <= 1'b0;
            end else begin
                r_ov <= p_valid;
                r_od <= p_data;
            end
        end else if (w_en && p_valid) begin
            r_sv <= 1'b1;
            r_sd <= p_data;
        end
    end

    assign o_out_valid = r_ov;
    assign o_out_data  = r_od;

endmodule

`default_nettype wire

[src/mf2_line_bank.sv]
`default_nettype none

module mf2_line_bank
    import mf2_pkg::*;
#(
    parameter int DEPTH = 2048
) (
    input  wire                      i_clk,
    input  wire                      i_en,
    input  wire                      i_we,
    input  wire  [$clog2(DEPTH)-1:0] i_waddr,
    input  t_pix                     i_wdata,
    input  wire  [$clog2(DEPTH)-1:0] i_raddr_a,
    input  wire  [$clog2(DEPTH)-1:0] i_raddr_b,
    output t_pix                     o_rdata_a,
    output t_pix                     o_rdata_b
);

    t_pix mem [DEPTH];
    t_pix r_rdata_a;
    t_pix r_rdata_b;

    // Write one pixel of the row held in this bank
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    // Read column and border pixels, hold while stalled
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rdata_a <= mem[i_raddr_a];
            r_rdata_b <= mem[i_raddr_b];
        end
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

`default_nettype wire

[src/mf2_bit_cell.sv]
`default_nettype none

module mf2_bit_cell
    import mf2_pkg::*;
#(
    parameter int N   = 49,
    parameter int BIT = 7
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_en,
    input  wire  [N-1:0][PIX_W-1:0]          i_vals,
    input  wire  [N-1:0]                     i_alive,
    input  wire  [$clog2(N+1)-1:0]           i_rank,
    input  t_pix                             i_bits,
    input  t_meta                            i_meta,
    output logic [N-1:0][PIX_W-1:0]          o_vals,
    output logic [N-1:0]                     o_alive,
    output logic [$clog2(N+1)-1:0]           o_rank,
    output t_pix                             o_bits,
    output t_meta                            o_meta
);

    localparam int CNT_W = $clog2(N+1);

    logic [CNT_W-1:0] zeros;
    logic             take_one;
    logic [N-1:0]     n_alive;
    logic [CNT_W-1:0] n_rank;
    t_pix             n_bits;

    logic [N-1:0][PIX_W-1:0] r_vals;
    logic [N-1:0]            r_alive;
    logic [CNT_W-1:0]        r_rank;
    t_pix                    r_bits;
    t_meta                   r_meta;

    // Count live candidates with a zero in this bit, then pick the bit
    always_comb begin
        zeros = '0;
        for (int i = 0; i < N; i++) begin
            zeros = zeros + CNT_W'(i_alive[i] & ~i_vals[i][BIT]);
        end
        take_one = (i_rank >= zeros);
        n_rank   = take_one ? (i_rank - zeros) : i_rank;
        for (int i = 0; i < N; i++) begin
            n_alive[i] = i_alive[i] & (i_vals[i][BIT] == take_one);
        end
        n_bits      = i_bits;
        n_bits[BIT] = take_one;
    end

    // Hand the candidates to the next cell
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_vals  <= i_vals;
            r_alive <= n_alive;
            r_rank  <= n_rank;
            r_bits  <= n_bits;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_meta <= '0;
        end else if (i_en) begin
            r_meta <= i_meta;
        end
    end

    assign o_vals  = r_vals;
    assign o_alive = r_alive;
    assign o_rank  = r_rank;
    assign o_bits  = r_bits;
    assign o_meta  = r_meta;

endmodule

`default_nettype wire

[tb/median_filter_2d_test.sv]
`timescale 1ns / 1ps

module median_filter_2d_test;
    import mf2_pkg::*;

    // Expected-pixel tracker: mirrors line store, window and raster counters
    class median_scoreboard;
        localparam int HALF  = 3;
        localparam int SPAN  = 7;
        localparam int SLOTS = 6;
        localparam int MAXW  = 2048;
        localparam int MAXH  = 2048;

        bit [7:0] line_mem [0:SLOTS*MAXW-1];
        bit [7:0] win [0:SPAN*SPAN-1];
        int unsigned in_col, in_row, out_col, out_row;
        int unsigned width_reg, height_reg;
        t_out expected_pixels[$];
        int errors;

        function new();
            foreach (win[i]) win[i] = 0;
            width_reg = WIDTH_RESET;
            height_reg = HEIGHT_RESET;
            errors = 0;
            restart();
        endfunction

        function void restart();
            in_col = 0;
            in_row = 0;
            out_col = 0;
            out_row = 0;
        endfunction

        function void set_reg(logic [CFG_IW-1:0] idx, logic [CFG_W-1:0] val);
            if (idx == REG_WIDTH) width_reg = val;
            else height_reg = val;
            restart();
        endfunction

        function int unsigned eff_w();
            if (width_reg < 1) return 1;
            if (width_reg > MAXW) return MAXW;
            return width_reg;
        endfunction

        function int unsigned eff_h();
            if (height_reg < 1) return 1;
            if (height_reg > MAXH) return MAXH;
            return height_reg;
        endfunction

        function bit [7:0] line_at(int unsigned r, int unsigned c);
            return line_mem[(r % SLOTS) * MAXW + (c % MAXW)];
        endfunction

        function bit [7:0] median_of_window();
            bit [7:0] v [0:48];
            bit [7:0] t;
            int j;
            foreach (win[i]) v[i] = win[i];
            for (int i = 1; i < 49; i++) begin
                t = v[i];
                j = i - 1;
                while (j >= 0 && v[j] > t) begin
                    v[j+1] = v[j];
                    j--;
                end
                v[j+1] = t;
            end
            return v[24];
        endfunction

        function void push_result(bit [7:0] pix, int unsigned w, int unsigned h);
            t_out r;
            r.pixel_out = pix;
            r.frame_last = (out_row == h - 1 && out_col == w - 1);
            expected_pixels.push_back(r);
            out_col++;
            if (out_col >= w) begin
                out_col = 0;
                out_row++;
            end
        endfunction

        // Note one accepted input item and queue the result it causes
        function void note_input(t_in it);
            int unsigned w, h, lag, idx;
            bit [7:0] column [0:SPAN-1];
            bit [7:0] v;
            w = eff_w();
            h = eff_h();
            lag = HALF * w + HALF;
            if (it.command == CMD_DRAIN) begin
                if (in_row >= h && out_row < h) push_result(line_at(out_row, out_col), w, h);
                return;
            end
            if (in_row >= h || in_col >= w) restart();
            idx = in_row * w + in_col;
            for (int k = 0; k < SLOTS; k++) column[k] = line_at(in_row + k, in_col);
            column[SLOTS] = it.pixel_in;
            for (int k = 0; k < SPAN; k++) begin
                for (int i = 0; i < SPAN - 1; i++) win[k*SPAN+i] = win[k*SPAN+i+1];
                win[k*SPAN+SPAN-1] = column[k];
            end
            if (idx >= lag && out_row < h) begin
                if (out_col >= HALF && out_col + HALF < w &&
                    out_row >= HALF && out_row + HALF < h)
                    v = median_of_window();
                else
                    v = line_at(out_row, out_col);
                push_result(v, w, h);
            end
            line_mem[(in_row % SLOTS) * MAXW + in_col] = it.pixel_in;
            in_col++;
            if (in_col >= w) begin
                in_col = 0;
                in_row++;
            end
        endfunction

        // Compare one output item with the oldest expected pixel
        function void check(t_out got);
            t_out exp_px;
            if (expected_pixels.size() == 0) begin
                $error("unexpected output item: pixel_out %0d frame_last %0d",
                       got.pixel_out, got.frame_last);
                errors++;
                return;
            end
            exp_px = expected_pixels.pop_front();
            if (got.pixel_out !== exp_px.pixel_out) begin
                $error("pixel_out: expected %0d actual %0d", exp_px.pixel_out, got.pixel_out);
                errors++;
            end
            if (got.frame_last !== exp_px.frame_last) begin
                $error("frame_last: expected %0d actual %0d",
                       exp_px.frame_last, got.frame_last);
                errors++;
            end
        endfunction

        function int pending();
            return expected_pixels.size();
        endfunction
    endclass

    logic              i_clk;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_ready;
    t_in               i_in_data;
    logic              o_out_valid;
    logic              i_out_ready;
    t_out              o_out_data;
    logic              i_cfg_we;
    logic [CFG_IW-1:0] i_cfg_index;
    logic [CFG_W-1:0]  i_cfg_data;

    median_scoreboard sb;
    int send_idle_pct;
    int recv_stall_pct;
    int hold_request;
    int hold_left;
    int pixels_sent;

    median_filter_2d uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // Clock
    initial i_clk = 1'b0;
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Receiver: random stalls, plus a long hold-off on request
    always @(posedge i_clk) begin
        if (hold_request) begin
            hold_left = 400;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Check each accepted output item
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) sb.check(o_out_data);
    end

    // Offer one item and hold it until accepted
    task automatic send_item(logic cmd, logic [7:0] pix);
        t_in it;
        it.command = cmd;
        it.pixel_in = pix;
        if ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < send_idle_pct) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= it;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        sb.note_input(it);
    endtask

    // Drop valid and wait until every expected pixel has come out
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() > 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IW-1:0] idx, logic [CFG_W-1:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.set_reg(idx, val);
    endtask

    // One frame of random pixels, optional stray drains, then the flush
    task automatic send_frame(int unsigned w_eff, int unsigned h_eff, int noise_pct,
                              int drain_extra);
        int unsigned n;
        n = w_eff * h_eff;
        for (int unsigned p = 0; p < n; p++) begin
            if ($urandom_range(99) < noise_pct) send_item(CMD_DRAIN, 8'($urandom_range(255)));
            send_item(CMD_PIXEL, 8'($urandom_range(255)));
            pixels_sent++;
        end
        for (int d = 0; d < 3 * w_eff + 3 + drain_extra; d++)
            send_item(CMD_DRAIN, 8'($urandom_range(255)));
    endtask

    task automatic set_idle_phase(int phase);
        case (phase % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 87; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 87; end
            default: begin send_idle_pct = 37; recv_stall_pct = 37; end
        endcase
    endtask

    // Timeout
    initial begin
        #60_000_000;
        $display("status: fail");
        $finish;
    end

    // Main sequence
    initial begin
        int unsigned w, h;
        int phase;
        sb = new();
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        i_out_ready = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = REG_WIDTH;
        i_cfg_data = '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_request = 0;
        hold_left = 0;
        pixels_sent = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Zero registers act as a 1x1 frame; drain before and after
        write_reg(REG_WIDTH, 12'd0);
        write_reg(REG_HEIGHT, 12'd0);
        send_item(CMD_DRAIN, 8'hff);
        send_item(CMD_PIXEL, 8'hff);
        send_item(CMD_DRAIN, 8'h00);
        send_item(CMD_DRAIN, 8'h00);
        wait_drained();

        // 7x7 frame: one true median, extremes and alternating bits
        write_reg(REG_WIDTH, 12'd7);
        write_reg(REG_HEIGHT, 12'd7);
        for (int p = 0; p < 49; p++)
            send_item(CMD_PIXEL, (p % 4 == 0) ? 8'h00 : (p % 4 == 1) ? 8'hff :
                                 (p % 4 == 2) ? 8'haa : 8'h55);
        // New frame without draining: held pixels drop
        send_item(CMD_PIXEL, 8'h80);
        wait_drained();

        // Long receiver hold-off while the sender keeps offering
        write_reg(REG_WIDTH, 12'd16);
        write_reg(REG_HEIGHT, 12'd10);
        hold_request = 1;
        send_frame(16, 10, 0, 0);
        wait_drained();

        // Random frames across idle phases
        pixels_sent = 0;
        phase = 0;
        while (pixels_sent < 750) begin
            set_idle_phase(phase);
            phase++;
            w = ($urandom_range(9) == 0) ? $urandom_range(1, 6) : $urandom_range(7, 20);
            h = ($urandom_range(9) == 0) ? $urandom_range(1, 6) : $urandom_range(7, 12);
            write_reg(REG_WIDTH, CFG_W'(w));
            write_reg(REG_HEIGHT, CFG_W'(h));
            if ($urandom_range(3) == 0) begin
                // Back-to-back frames, the first cut short of its flush
                send_frame(w, h, 5, -(3 * w + 3) + $urandom_range(3 * w + 3));
                send_frame(w, h, 0, $urandom_range(3));
            end else begin
                send_frame(w, h, 3, $urandom_range(3));
            end
            wait_drained();
        end

        i_in_valid <= 1'b0;
        wait_drained();
        repeat (30) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("status: pass");
        end else begin
            if (sb.pending() > 0) $error("%0d expected pixels never arrived", sb.pending());
            $display("status: fail");
        end
        $finish;
    end

endmodule
